[rtl/usb_frame_loss_detector_unit_assert.svh]
// assertion macros shared by the frame loss detector rtl
// no dependencies; included by the modules that carry checks
`ifndef USB_FRAME_LOSS_DETECTOR_UNIT_ASSERT_SVH
`define USB_FRAME_LOSS_DETECTOR_UNIT_ASSERT_SVH

// same-cycle implication, disabled during reset
`define UFLD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define UFLD_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/ufld_pkg.sv]
// types and constants for the usb frame loss detector
// no dependencies; used by ufld_eval and usb_frame_loss_detector_unit
package ufld_pkg;

    localparam int unsigned AGE_W     = 23;
    localparam int unsigned CFG_IDX_W = 8;
    localparam int unsigned CFG_DAT_W = 32;
    localparam int unsigned THR_W     = 30;
    localparam int unsigned HOLD_W    = 31;

    localparam logic [31:0]        MIN_PASS_US      = 32'd1000;
    localparam logic [THR_W-1:0]   STALE_THR_RESET  = 30'd300000;
    localparam logic [HOLD_W-1:0]  REATTACH_RESET   = 31'd2000000;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_STALE_THRESHOLD = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REATTACH_HOLD   = 8'd1;

    // us -> ms: (x >> 3) * MS_RECIP >> MS_SHIFT is exact for any 32-bit x
    localparam int unsigned MS_SHIFT = 36;
    localparam logic [29:0] MS_RECIP = 30'd549755814;

    typedef struct packed {
        logic [31:0] now_us;
        logic [10:0] frame_count;
        logic        wake_pending;
        logic        host_configured;
        logic        resume_event;
        logic        reattach_event;
    } t_in;

    typedef struct packed {
        logic             evaluated;
        logic             frames_seen;
        logic [AGE_W-1:0] frame_age_ms;
        logic             frame_loss;
        logic             in_reattach_hold;
    } t_out;

    // result of a pass before the ms conversion
    typedef struct packed {
        logic        evaluated;
        logic        frames_seen;
        logic [31:0] age_us;
        logic        frame_loss;
        logic        in_reattach_hold;
    } t_mid;

    typedef struct packed {
        logic                 we;
        logic [CFG_IDX_W-1:0] index;
        logic [CFG_DAT_W-1:0] data;
    } t_cfg_wr;

endpackage

[rtl/ufld_eval.sv]
// watchdog state and per-pass evaluation: skip test, sampling, hold timer, verdict
// depends on ufld_pkg and usb_frame_loss_detector_unit_assert.svh
`include "usb_frame_loss_detector_unit_assert.svh"

module ufld_eval (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  ufld_pkg::t_cfg_wr i_cfg,
    input  logic             i_fire,
    input  ufld_pkg::t_in    i_item,
    output ufld_pkg::t_mid   o_mid
);

    logic [ufld_pkg::THR_W-1:0]  r_thr;
    logic [ufld_pkg::HOLD_W-1:0] r_hold_us;

    logic [31:0] r_lct, n_lct;
    logic [31:0] r_lrt, n_lrt;
    logic [10:0] r_lfc, n_lfc;
    logic        r_fsf, n_fsf;
    logic        r_hs, n_hs;
    logic [31:0] r_lpt, n_lpt;
    logic        r_ra, n_ra;
    logic [31:0] r_ras, n_ras;

    logic [31:0] now, dp, dc, dr, drd, dh, d, lrt1;
    logic [31:0] thr32, cap32, hold32;
    logic        ev, skip, eval_ok, sample, changed, gap_stale, drift;
    logic        act1, expire, hold;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr     <= ufld_pkg::STALE_THR_RESET;
            r_hold_us <= ufld_pkg::REATTACH_RESET;
        end else if (i_cfg.we) begin
            case (i_cfg.index)
                ufld_pkg::REG_STALE_THRESHOLD: r_thr     <= i_cfg.data[ufld_pkg::THR_W-1:0];
                ufld_pkg::REG_REATTACH_HOLD:   r_hold_us <= i_cfg.data[ufld_pkg::HOLD_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        now    = (i_item.now_us == 32'd0) ? 32'd1 : i_item.now_us;
        thr32  = {2'b00, r_thr};
        cap32  = {1'b0, r_thr, 1'b0};
        hold32 = {1'b0, r_hold_us};
        ev     = i_item.resume_event | i_item.reattach_event;

        dp      = now - r_lpt;
        skip    = (r_lpt != 32'd0) && (dp < ufld_pkg::MIN_PASS_US);
        eval_ok = !skip;

        // events land before the pass, so differences against them are zero
        dc   = ev ? 32'd0 : (now - r_lct);
        lrt1 = i_item.reattach_event ? now : r_lrt;
        dr   = i_item.reattach_event ? 32'd0 : (now - r_lrt);

        sample    = eval_ok && !i_item.wake_pending &&
                    !((lrt1 != 32'd0) && (dr < ufld_pkg::MIN_PASS_US));
        changed   = !r_fsf || (r_lfc != i_item.frame_count);
        gap_stale = (lrt1 != 32'd0) && (dr >= thr32);
        drift     = dc > cap32;

        n_lct = ev ? now : r_lct;
        d     = dc;
        n_lfc = r_lfc;
        if (sample) begin
            if (changed) begin
                n_lfc = i_item.frame_count;
                n_lct = now;
                d     = 32'd0;
            end else if (gap_stale) begin
                n_lct = now;
                d     = 32'd0;
            end else if (drift) begin
                // hold the age at twice the threshold
                n_lct = now - cap32;
                d     = cap32;
            end
        end
        n_lrt = sample ? now : lrt1;
        drd   = sample ? 32'd0 : dr;
        n_fsf = r_fsf | sample;
        n_hs  = r_hs | (eval_ok & i_item.host_configured);
        n_lpt = eval_ok ? now : r_lpt;

        act1   = i_item.reattach_event | r_ra;
        n_ras  = i_item.reattach_event ? now : r_ras;
        dh     = i_item.reattach_event ? 32'd0 : (now - r_ras);
        expire = dh >= hold32;
        hold   = eval_ok && act1 && !expire;
        n_ra   = act1 && !(eval_ok && expire);

        o_mid.evaluated        = eval_ok;
        o_mid.frames_seen      = n_fsf;
        o_mid.age_us           = (eval_ok && n_fsf) ? d : 32'd0;
        o_mid.in_reattach_hold = hold;
        o_mid.frame_loss       = eval_ok && !hold && n_hs && n_fsf &&
                                 (n_lrt != 32'd0) && (drd < thr32) && (d >= thr32);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lct <= '0;
            r_lrt <= '0;
            r_lfc <= '0;
            r_fsf <= 1'b0;
            r_hs  <= 1'b0;
            r_lpt <= '0;
            r_ra  <= 1'b0;
            r_ras <= '0;
        end else if (i_fire) begin
            r_lct <= n_lct;
            r_lrt <= n_lrt;
            r_lfc <= n_lfc;
            r_fsf <= n_fsf;
            r_hs  <= n_hs;
            r_lpt <= n_lpt;
            r_ra  <= n_ra;
            r_ras <= n_ras;
        end
    end

    `UFLD_ASSERT_NXT(a_pass_stamped, i_clk, i_rst_n, i_fire, r_lpt != 32'd0, "pass time left at never")
    `UFLD_ASSERT_NXT(a_seen_sticky, i_clk, i_rst_n, r_fsf, r_fsf, "frame seen flag dropped")
    `UFLD_ASSERT_IMP(a_seen_has_read, i_clk, i_rst_n, r_fsf, r_lrt != 32'd0, "sample without read time")
    `UFLD_ASSERT_NXT(a_reattach_start, i_clk, i_rst_n, i_fire && i_item.reattach_event,
        r_ras == $past(now), "reattach start not stamped")
    `UFLD_ASSERT_IMP(a_lost_no_hold, i_clk, i_rst_n, o_mid.frame_loss,
        !o_mid.in_reattach_hold && o_mid.frames_seen, "verdict during hold or before sample")

endmodule

[rtl/usb_frame_loss_detector_unit.sv]
// top level of the usb frame loss detector: handshakes, pipeline and us-to-ms conversion
// depends on ufld_pkg and ufld_eval

// One scan pass is one input transfer; one result transfer comes back for each.
// The block takes a pass every clock cycle unless a stalled output has filled
// all three register stages it runs through: an input register, the evaluation
// stage that updates the watchdog state, and the result register fed by the
// single 29 x 30 bit multiplier that turns the age in microseconds into
// milliseconds. Each stage moves on its own, so a result waiting at the output
// does not stop passes from entering until all three stages are full.
// Configuration writes are always taken (ready is tied high); indexes outside
// the two registers are ignored.
module usb_frame_loss_detector_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  ufld_pkg::t_in                    i_in,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output ufld_pkg::t_out                   o_out,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [ufld_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [ufld_pkg::CFG_DAT_W-1:0]   i_cfg_data
);

    logic              r_in_v;
    ufld_pkg::t_in     r_in;
    logic              r_mid_v;
    ufld_pkg::t_mid    r_mid;
    ufld_pkg::t_mid    n_mid;
    logic              r_out_v;
    logic              r_ev, r_seen, r_lost, r_hold;
    logic [58:0]       r_prod;

    logic              out_take, mid_take, in_take, fire;
    ufld_pkg::t_cfg_wr cfg;

    assign out_take = !r_out_v || i_out_ready;
    assign mid_take = !r_mid_v || out_take;
    assign in_take  = !r_in_v || mid_take;
    assign fire     = r_in_v && mid_take;

    assign o_in_ready  = in_take;
    assign o_cfg_ready = 1'b1;

    assign cfg.we    = i_cfg_valid;
    assign cfg.index = i_cfg_index;
    assign cfg.data  = i_cfg_data;

    ufld_eval u_eval (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_fire  (fire),
        .i_item  (r_in),
        .o_mid   (n_mid)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v  <= 1'b0;
            r_mid_v <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (in_take)  r_in_v  <= i_in_valid;
            if (mid_take) r_mid_v <= r_in_v;
            if (out_take) r_out_v <= r_mid_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take && i_in_valid) r_in <= i_in;
        if (fire) r_mid <= n_mid;
        if (out_take && r_mid_v) begin
            r_ev   <= r_mid.evaluated;
            r_seen <= r_mid.frames_seen;
            r_lost <= r_mid.frame_loss;
            r_hold <= r_mid.in_reattach_hold;
            // divide by 8 then by 125 through the reciprocal
            r_prod <= 59'(r_mid.age_us[31:3]) * 59'(ufld_pkg::MS_RECIP);
        end
    end

    assign o_out_valid            = r_out_v;
    assign o_out.evaluated        = r_ev;
    assign o_out.frames_seen      = r_seen;
    assign o_out.frame_age_ms     = r_prod[ufld_pkg::MS_SHIFT +: ufld_pkg::AGE_W];
    assign o_out.frame_loss       = r_lost;
    assign o_out.in_reattach_hold = r_hold;

endmodule

[tb/sv/tb.sv]
// self-checking testbench for usb_frame_loss_detector_unit: directed passes, then random scan passes
// under several register settings, each result checked against a table verdict or a behavioral watchdog predictor
// depends on ufld_pkg and the usb_frame_loss_detector_unit rtl
module tb;

    localparam int unsigned US_PER_MS     = 1000;
    localparam int          NUM_DIR       = 24;
    localparam int          NUM_PHASES    = 7;
    localparam int          PASSES_PER_PH = 190;
    localparam int          SQUEEZE_CYCLES = 200;
    localparam int          DRAIN_CYCLES  = 6;
    localparam int          STALL_LIMIT   = 2000;

    // unused register index, writes to it must leave both registers alone
    localparam logic [ufld_pkg::CFG_IDX_W-1:0] REG_UNUSED = 8'd2;

    // flag nibble in t_in order: wake_pending, host_configured, resume_event, reattach_event
    localparam logic [3:0] F_NONE       = 4'b0000;
    localparam logic [3:0] F_REATTACH   = 4'b0001;
    localparam logic [3:0] F_RESUME     = 4'b0010;
    localparam logic [3:0] F_CONFIGURED = 4'b0100;
    localparam logic [3:0] F_WAKE       = 4'b1000;

    typedef struct packed {
        logic [31:0] now_us;
        logic [10:0] count;
        logic [3:0]  flags;
        logic        typed;
        logic [26:0] verdict;   // {evaluated, frames_seen, age_ms, frame_loss, in_hold}
    } t_dir_row;

    logic           clk = 1'b0;
    logic           rst_n = 1'b0;
    logic           in_valid = 1'b0;
    logic           in_ready;
    ufld_pkg::t_in  in_pass = '0;
    logic           out_valid;
    logic           out_ready = 1'b0;
    ufld_pkg::t_out out_verdict;
    logic           cfg_valid = 1'b0;
    logic           cfg_ready;
    logic [ufld_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [ufld_pkg::CFG_DAT_W-1:0] cfg_data = '0;

    // watchdog predictor state and registers
    logic [ufld_pkg::THR_W-1:0]  thr_us;
    logic [ufld_pkg::HOLD_W-1:0] hold_us;
    logic [31:0]       wd_change_t;
    logic [31:0]       wd_read_t;
    logic [10:0]       wd_count;
    logic              wd_seen;
    logic              wd_host;
    logic [31:0]       wd_pass_t;
    logic              wd_hold_on;
    logic [31:0]       wd_hold_start;

    ufld_pkg::t_out pending_verdicts[$];

    logic [31:0] clock_us;
    logic [10:0] cur_count;
    bit          calm = 1'b0;
    bit          squeeze_req = 1'b0;
    int          errors = 0;
    int          passes_sent = 0;
    int          verdicts_checked = 0;
    int          skipped_seen = 0;
    int          lost_seen = 0;
    int          hold_seen = 0;
    int          cfg_writes = 0;
    int          squeezes = 0;
    int          idle_cycles = 0;

    logic [31:0] thr_plan [NUM_PHASES] = '{32'd5000, 32'd1000, 32'd20000, 32'd1000000000,
                                          32'hFFFF_FFFF, 32'd0, 32'd300000};
    logic [31:0] hold_plan [NUM_PHASES] = '{32'd20000, 32'd0, 32'd150000, 32'd2000000000,
                                           32'hFFFF_FFFF, 32'd5000, 32'd2000000};

    // default registers: 300 ms threshold, 2 s reattach hold
    t_dir_row dir_table [NUM_DIR] = '{
        '{32'd0,          11'd0,    F_NONE,       1'b1, {1'b1, 1'b1, 23'd0, 1'b0, 1'b0}},
        '{32'd500,        11'd5,    F_CONFIGURED, 1'b1, {1'b0, 1'b1, 23'd0, 1'b0, 1'b0}},
        '{32'd1001,       11'd2047, F_CONFIGURED, 1'b0, 27'd0},
        '{32'd101001,     11'd2047, F_CONFIGURED, 1'b0, 27'd0},
        '{32'd201001,     11'd2047, F_CONFIGURED, 1'b0, 27'd0},
        '{32'd301001,     11'd2047, F_CONFIGURED, 1'b1, {1'b1, 1'b1, 23'd300, 1'b1, 1'b0}},
        '{32'd401001,     11'd2047, F_CONFIGURED, 1'b0, 27'd0},
        '{32'd501001,     11'd2047, F_CONFIGURED, 1'b0, 27'd0},
        '{32'd601001,     11'd2047, F_CONFIGURED, 1'b0, 27'd0},
        '{32'd701001,     11'd2047, F_CONFIGURED, 1'b1, {1'b1, 1'b1, 23'd600, 1'b1, 1'b0}},
        '{32'd701500,     11'd2047, F_WAKE,       1'b1, {1'b0, 1'b1, 23'd0, 1'b0, 1'b0}},
        '{32'd1101001,    11'd2047, F_CONFIGURED, 1'b1, {1'b1, 1'b1, 23'd0, 1'b0, 1'b0}},
        '{32'd1201001,    11'd2047, F_WAKE | F_CONFIGURED, 1'b0, 27'd0},
        '{32'd1301001,    11'd2047, F_WAKE,       1'b0, 27'd0},
        '{32'd1401001,    11'd2047, F_WAKE,       1'b0, 27'd0},
        '{32'd1501001,    11'd7,    F_CONFIGURED | F_REATTACH, 1'b1,
          {1'b1, 1'b1, 23'd0, 1'b0, 1'b1}},
        '{32'd1501500,    11'd7,    F_RESUME,     1'b1, {1'b0, 1'b1, 23'd0, 1'b0, 1'b0}},
        '{32'd1601001,    11'd7,    F_CONFIGURED | F_RESUME | F_REATTACH, 1'b0, 27'd0},
        '{32'd3601000,    11'd7,    F_CONFIGURED, 1'b0, 27'd0},
        '{32'd3602001,    11'd7,    F_CONFIGURED, 1'b0, 27'd0},
        '{32'hFFFF_FF00,  11'd0,    F_NONE,       1'b0, 27'd0},
        '{32'h0000_0000,  11'd0,    F_NONE,       1'b1, {1'b0, 1'b1, 23'd0, 1'b0, 1'b0}},
        '{32'h0000_0400,  11'd1,    F_CONFIGURED, 1'b0, 27'd0},
        '{32'hFFFF_FFFF,  11'd2047, F_WAKE | F_CONFIGURED | F_RESUME | F_REATTACH, 1'b0, 27'd0}
    };

    usb_frame_loss_detector_unit dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_pass),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_verdict),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    function automatic void watchdog_reset();
        thr_us        = ufld_pkg::STALE_THR_RESET;
        hold_us       = ufld_pkg::REATTACH_RESET;
        wd_change_t   = '0;
        wd_read_t     = '0;
        wd_count      = '0;
        wd_seen       = 1'b0;
        wd_host       = 1'b0;
        wd_pass_t     = '0;
        wd_hold_on    = 1'b0;
        wd_hold_start = '0;
    endfunction

    // one scan pass through the watchdog, updating its state
    function automatic ufld_pkg::t_out watchdog_pass(input ufld_pkg::t_in p);
        logic [31:0]    now;
        logic [31:0]    gap;
        logic [31:0]    cap;
        logic [31:0]    age;
        logic           hold;
        logic           lost;
        ufld_pkg::t_out r;
        r   = '0;
        now = (p.now_us == 32'd0) ? 32'd1 : p.now_us;
        if (p.resume_event)
            wd_change_t = now;
        if (p.reattach_event) begin
            wd_hold_on    = 1'b1;
            wd_hold_start = now;
            wd_change_t   = now;
            wd_read_t     = now;
        end
        if (wd_pass_t != 32'd0 && (now - wd_pass_t) < ufld_pkg::MIN_PASS_US) begin
            r.frames_seen = wd_seen;
            return r;
        end
        if (p.host_configured)
            wd_host = 1'b1;
        wd_pass_t = now;
        // the counter is read at most once per ms
        if (!p.wake_pending &&
            !(wd_read_t != 32'd0 && (now - wd_read_t) < ufld_pkg::MIN_PASS_US)) begin
            gap       = (wd_read_t != 32'd0) ? now - wd_read_t : 32'd0;
            cap       = {1'b0, thr_us, 1'b0};
            wd_read_t = now;
            if (!wd_seen || wd_count != p.frame_count) begin
                wd_seen     = 1'b1;
                wd_count    = p.frame_count;
                wd_change_t = now;
            end else if (gap >= {2'b00, thr_us}) begin
                wd_change_t = now;
            end else if ((now - wd_change_t) > cap) begin
                wd_change_t = now - cap;
            end
        end
        age = wd_seen ? (now - wd_change_t) / US_PER_MS : 32'd0;
        hold = 1'b0;
        if (wd_hold_on) begin
            if ((now - wd_hold_start) >= {1'b0, hold_us})
                wd_hold_on = 1'b0;
            else
                hold = 1'b1;
        end
        lost = 1'b0;
        if (!hold && wd_host && wd_seen && wd_read_t != 32'd0 &&
            (now - wd_read_t) < {2'b00, thr_us})
            lost = (now - wd_change_t) >= {2'b00, thr_us};
        r.evaluated        = 1'b1;
        r.frames_seen      = wd_seen;
        r.frame_age_ms     = age[ufld_pkg::AGE_W-1:0];
        r.frame_loss       = lost;
        r.in_reattach_hold = hold;
        return r;
    endfunction

    // mostly back to back, some short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 65)
            return 0;
        else if (r < 92)
            return $urandom_range(3, 1);
        else
            return $urandom_range(40, 8);
    endfunction

    // time steps cluster around the 1 ms pass spacing and the stale threshold
    function automatic ufld_pkg::t_in next_scan_pass();
        ufld_pkg::t_in p;
        int unsigned   r;
        int unsigned   span;
        int unsigned   step;
        span = (thr_us < 2000) ? 2000 : ((thr_us > 20000000) ? 20000000 : thr_us);
        r = $urandom_range(99);
        if (r < 15)
            step = $urandom_range(999);
        else if (r < 55)
            step = $urandom_range(3000, 1000);
        else if (r < 80)
            step = $urandom_range(span, 1000);
        else if (r < 90)
            step = thr_us + $urandom_range(2) - 1;
        else if (r < 96)
            step = 2 * thr_us + $urandom_range(4000);
        else
            step = $urandom;
        clock_us = clock_us + step;
        r = $urandom_range(99);
        if (r >= 90)
            cur_count = 11'($urandom_range(2047));
        else if (r >= 65)
            cur_count = cur_count + 11'($urandom_range(3, 1));
        p.now_us          = clock_us;
        p.frame_count     = cur_count;
        p.wake_pending    = ($urandom_range(99) < 10);
        p.host_configured = ($urandom_range(99) < 85);
        p.resume_event    = ($urandom_range(99) < 4);
        p.reattach_event  = ($urandom_range(99) < 4);
        return p;
    endfunction

    task automatic send_pass(input ufld_pkg::t_in p, input bit typed,
                             input ufld_pkg::t_out verdict);
        int             gap;
        ufld_pkg::t_out predicted;
        gap = (calm || squeeze_req) ? 0 : pick_gap();
        @(negedge clk);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_pass  <= p;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        predicted = watchdog_pass(p);
        pending_verdicts.push_back(typed ? verdict : predicted);
        passes_sent++;
    endtask

    task automatic write_reg(input logic [ufld_pkg::CFG_IDX_W-1:0] idx,
                             input logic [ufld_pkg::CFG_DAT_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        if (idx == ufld_pkg::REG_STALE_THRESHOLD)
            thr_us = data[ufld_pkg::THR_W-1:0];
        else if (idx == ufld_pkg::REG_REATTACH_HOLD)
            hold_us = data[ufld_pkg::HOLD_W-1:0];
        cfg_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // stop offering passes and wait for every outstanding result
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_verdicts.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic report(input string field, input int unsigned want, input int unsigned got);
        $display("%0t: %s mismatch, expected %0d got %0d", $time, field, want, got);
        errors++;
    endtask

    // receiver: random back-pressure, plus one long hold-off on request
    initial begin
        int stall;
        stall = 0;
        forever begin
            @(negedge clk);
            if (squeeze_req) begin
                out_ready <= 1'b0;
                repeat (SQUEEZE_CYCLES) @(negedge clk);
                squeeze_req = 1'b0;
                squeezes++;
            end else if (stall > 0) begin
                out_ready <= 1'b0;
                stall--;
            end else begin
                out_ready <= 1'b1;
                stall = calm ? 0 : pick_gap();
            end
        end
    end

    always @(posedge clk) begin
        ufld_pkg::t_out want;
        if (rst_n && out_valid && out_ready) begin
            if (pending_verdicts.size() == 0) begin
                $display("%0t: unexpected result transfer %h", $time, out_verdict);
                errors++;
            end else begin
                want = pending_verdicts.pop_front();
                if (out_verdict.evaluated !== want.evaluated)
                    report("evaluated", want.evaluated, out_verdict.evaluated);
                if (out_verdict.frames_seen !== want.frames_seen)
                    report("frames_seen", want.frames_seen, out_verdict.frames_seen);
                if (out_verdict.frame_age_ms !== want.frame_age_ms)
                    report("frame_age_ms", want.frame_age_ms, out_verdict.frame_age_ms);
                if (out_verdict.frame_loss !== want.frame_loss)
                    report("frame_loss", want.frame_loss, out_verdict.frame_loss);
                if (out_verdict.in_reattach_hold !== want.in_reattach_hold)
                    report("in_reattach_hold", want.in_reattach_hold,
                           out_verdict.in_reattach_hold);
                verdicts_checked++;
                if (!want.evaluated)
                    skipped_seen++;
                if (want.frame_loss)
                    lost_seen++;
                if (want.in_reattach_hold)
                    hold_seen++;
            end
        end
    end

    // cycles with no transfer on any channel
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
            $display("usb_frame_loss_detector_unit regression: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        t_dir_row      row;
        ufld_pkg::t_in p;
        int            k;
        int            ph;
        watchdog_reset();
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (k = 0; k < NUM_DIR; k++) begin
            row = dir_table[k];
            send_pass({row.now_us, row.count, row.flags}, row.typed, row.verdict);
        end
        clock_us  = 32'hFFFF_FFFF;
        cur_count = 11'd2047;

        for (ph = 0; ph < NUM_PHASES; ph++) begin
            drain();
            if (ph % 2 == 0) begin
                write_reg(ufld_pkg::REG_STALE_THRESHOLD, thr_plan[ph]);
                write_reg(ufld_pkg::REG_REATTACH_HOLD, hold_plan[ph]);
            end else begin
                write_reg(ufld_pkg::REG_REATTACH_HOLD, hold_plan[ph]);
                write_reg(ufld_pkg::REG_STALE_THRESHOLD, thr_plan[ph]);
            end
            if (ph == 2)
                write_reg(REG_UNUSED, $urandom);
            for (k = 0; k < PASSES_PER_PH; k++) begin
                calm = (k >= 60 && k < 100);
                // fill the pipeline against a stalled output
                if (ph == 0 && k == 20)
                    squeeze_req = 1'b1;
                p = next_scan_pass();
                send_pass(p, 1'b0, '0);
            end
            calm = 1'b0;
        end
        drain();

        $display("covered %0d passes (%0d skipped, %0d lost, %0d in reattach hold)",
                 passes_sent, skipped_seen, lost_seen, hold_seen);
        $display("over %0d register writes and %0d long output stall(s), %0d mismatches",
                 cfg_writes, squeezes, errors);
        if (errors == 0)
            $display("usb_frame_loss_detector_unit regression: pass");
        else
            $display("usb_frame_loss_detector_unit regression: fail");
        $finish;
    end

endmodule
